/* hw/rtl/xfh_pkg.sv */
// Package for the XOR folding string hash.
// Shared widths, register map and reset values; no dependencies.
package xfh_pkg;

    localparam int MAX_HASH_BITS_DEF = 32;
    localparam int BYTE_BITS         = 8;
    localparam int HASH_BITS_W       = 6;
    localparam int HASH_VALUE_W      = 32;
    localparam int APB_DATA_W        = 32;
    localparam int APB_ADDR_W        = 3;

    // register indexes (byte address = 4 * index)
    localparam logic [APB_ADDR_W-3:0] REG_HASH_BITS = 1'b0;

    localparam logic [HASH_BITS_W-1:0] HASH_BITS_RST = 6'd8;
    localparam logic [HASH_BITS_W-1:0] HASH_BITS_MIN = 6'd8;

endpackage

/* hw/rtl/xfh_if.sv */
// Stream interfaces for the XOR folding string hash: byte input, hash output.
// Depends on xfh_pkg.
interface xfh_in_if
    import xfh_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [BYTE_BITS-1:0] data_byte;
    logic                 last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface xfh_out_if
    import xfh_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [HASH_VALUE_W-1:0] hash_value;

    modport source (output valid, output hash_value, input ready);
    modport sink   (input valid, input hash_value, output ready);
endinterface

/* hw/rtl/xor_fold_string_hash.sv */
// Top level of the XOR folding string hash.
// Depends on xfh_pkg and the stream interfaces in xfh_if.sv.
//
//  channel   dir  beat contents                 handshake
//  byte_in   in   data_byte[7:0], last_byte      valid/ready
//  hash_out  out  hash_value[31:0]               valid/ready, one beat per word
//  apb       in   hash_bits at address 0         psel/penable, pready tied high
//
// One byte per cycle sustained, except while a last byte waits on a full output
// register. A byte is held in the input register, and the fold logic updates
// buffer, count and accumulator from it. Folding the last byte loads the hash
// into the output register, from which the sink takes it.
// A full output register stalls only last bytes; other bytes keep flowing.
// Reset clears the valid flags and word state and sets hash_bits to 8; no clearing pass.
module xor_fold_string_hash
    import xfh_pkg::*;
#(
    parameter int MAX_HASH_BITS = MAX_HASH_BITS_DEF
)(
    input  logic                  clk,
    input  logic                  rst_n,
    xfh_in_if.sink                byte_in,
    xfh_out_if.source             hash_out,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int BUF_W = MAX_HASH_BITS + BYTE_BITS;
    localparam int CNT_W = $clog2(BUF_W);
    localparam int ITER  = (MAX_HASH_BITS + BYTE_BITS - 1) / BYTE_BITS;
    localparam int EXT_W = (MAX_HASH_BITS > HASH_VALUE_W) ? MAX_HASH_BITS : HASH_VALUE_W;

    // configuration
    logic [HASH_BITS_W-1:0] hash_bits_reg;
    logic [HASH_BITS_W-1:0] w_clamp;
    logic [CNT_W-1:0]       w_eff;
    logic                   reg_hit;

    // input stage
    logic                 s1_valid_reg, s1_valid_next;
    logic [BYTE_BITS-1:0] s1_byte_reg;
    logic                 s1_last_reg;

    // fold state
    logic [MAX_HASH_BITS-1:0] buf_reg, buf_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic [MAX_HASH_BITS-1:0] acc_reg, acc_next;

    // output stage
    logic                    out_valid_reg, out_valid_next;
    logic [HASH_VALUE_W-1:0] hash_reg, hash_next;

    logic fire;
    logic out_load;

    logic [BUF_W-1:0]         buf_w;
    logic [CNT_W-1:0]         cnt_w;
    logic [CNT_W-1:0]         rest;
    logic [MAX_HASH_BITS-1:0] acc_w;
    logic [MAX_HASH_BITS-1:0] acc_fin;
    logic [BUF_W-1:0]         chunk_mask;
    logic [MAX_HASH_BITS-1:0] hash_mask;
    logic [EXT_W-1:0]         hash_ext;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[APB_ADDR_W-1:2] == REG_HASH_BITS);
    assign prdata  = reg_hit ? APB_DATA_W'(hash_bits_reg) : '0;

    always_comb
    begin
        if (hash_bits_reg < HASH_BITS_MIN)
            w_clamp = HASH_BITS_MIN;
        else if (hash_bits_reg > HASH_BITS_W'(MAX_HASH_BITS))
            w_clamp = HASH_BITS_W'(MAX_HASH_BITS);
        else
            w_clamp = hash_bits_reg;
    end

    assign w_eff      = CNT_W'(w_clamp);
    assign chunk_mask = ~({BUF_W{1'b1}} << w_eff);
    assign hash_mask  = ~({MAX_HASH_BITS{1'b1}} << w_eff);
    assign hash_ext   = EXT_W'(acc_fin & hash_mask);

    // last bytes wait for room in the output register
    assign out_load      = !out_valid_reg || hash_out.ready;
    assign fire          = s1_valid_reg && (!s1_last_reg || out_load);
    assign byte_in.ready = !s1_valid_reg || fire;

    // fold: at most one chunk per byte; several after hash_bits shrinks mid-word
    always_comb
    begin
        buf_w = {buf_reg, s1_byte_reg};
        cnt_w = cnt_reg + CNT_W'(BYTE_BITS);
        acc_w = acc_reg;
        rest  = '0;
        for (int i = 0; i < ITER; i++)
        begin
            if (cnt_w >= w_eff)
            begin
                rest  = cnt_w - w_eff;
                acc_w = acc_w ^ MAX_HASH_BITS'((buf_w >> rest) & chunk_mask);
                buf_w = buf_w & ~({BUF_W{1'b1}} << rest);
                cnt_w = rest;
            end
        end
        acc_fin = acc_w ^ buf_w[MAX_HASH_BITS-1:0];
    end

    always_comb
    begin
        s1_valid_next  = s1_valid_reg;
        buf_next       = buf_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        hash_next      = hash_reg;

        if (out_valid_reg && hash_out.ready)
            out_valid_next = 1'b0;

        if (fire)
        begin
            s1_valid_next = 1'b0;
            if (s1_last_reg)
            begin
                buf_next       = '0;
                cnt_next       = '0;
                acc_next       = '0;
                out_valid_next = 1'b1;
                hash_next      = hash_ext[HASH_VALUE_W-1:0];
            end
            else
            begin
                buf_next = buf_w[MAX_HASH_BITS-1:0];
                cnt_next = cnt_w;
                acc_next = acc_w;
            end
        end

        if (byte_in.valid && byte_in.ready)
            s1_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hash_bits_reg <= HASH_BITS_RST;
            s1_valid_reg  <= 1'b0;
            buf_reg       <= '0;
            cnt_reg       <= '0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && reg_hit)
                hash_bits_reg <= pwdata[HASH_BITS_W-1:0];
            s1_valid_reg  <= s1_valid_next;
            buf_reg       <= buf_next;
            cnt_reg       <= cnt_next;
            acc_reg       <= acc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            s1_byte_reg <= byte_in.data_byte;
            s1_last_reg <= byte_in.last_byte;
        end
        hash_reg <= hash_next;
    end

    assign hash_out.valid      = out_valid_reg;
    assign hash_out.hash_value = hash_reg;

`ifndef ASSERT_OFF
    // fewer buffered bits than the widest chunk between bytes
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg < CNT_W'(MAX_HASH_BITS))
        else $error("buffered count out of range");

    // bits above the buffered count are always cleared
    a_buf_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (buf_reg >> cnt_reg) == '0)
        else $error("stale bits above buffered count");

    // a folded last byte loads the output and clears the word state
    a_last_clear: assert property (@(posedge clk) disable iff (!rst_n)
        fire && s1_last_reg |=> out_valid_reg && cnt_reg == '0 && acc_reg == '0)
        else $error("word state not cleared after last byte");
`endif

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Testbench for xor_fold_string_hash: random words with random stalls on both sides,
// checked against a folding predictor in a small scoreboard class.
// Depends on xfh_pkg, the stream interfaces in xfh_if.sv and the RTL top level.
module tb_top;
    import xfh_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 7;
    localparam int DRAIN_CYCLES = 6;
    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int BUF_BITS     = MAX_HASH_BITS_DEF + BYTE_BITS;
    localparam logic [APB_ADDR_W-1:0] HASH_BITS_ADDR = {REG_HASH_BITS, 2'b00};

    class hash_scoreboard;
        logic [HASH_BITS_W-1:0]  width_reg = HASH_BITS_RST;
        longint unsigned         fold_buf  = 0;
        int unsigned             fold_cnt  = 0;
        logic [HASH_VALUE_W-1:0] fold_acc  = '0;
        logic [HASH_VALUE_W-1:0] hash_q[$];
        int unsigned             errors    = 0;

        function void set_width(logic [APB_DATA_W-1:0] v);
            width_reg = v[HASH_BITS_W-1:0];
        endfunction

        // fold one accepted byte; queue the hash when the word ends
        function void note_byte(logic [BYTE_BITS-1:0] d, logic l);
            int unsigned     w;
            int unsigned     rest;
            longint unsigned wmask;
            w = width_reg;
            if (w < BYTE_BITS) w = BYTE_BITS;
            if (w > MAX_HASH_BITS_DEF) w = MAX_HASH_BITS_DEF;
            wmask = (64'd1 << w) - 64'd1;
            fold_buf = ((fold_buf << BYTE_BITS) | longint'(d)) & ((64'd1 << BUF_BITS) - 64'd1);
            fold_cnt += BYTE_BITS;
            while (fold_cnt >= w)
            begin
                rest = fold_cnt - w;
                fold_acc ^= HASH_VALUE_W'((fold_buf >> rest) & wmask);
                fold_buf &= (64'd1 << rest) - 64'd1;
                fold_cnt = rest;
            end
            if (l)
            begin
                // leftover bits go in at the low end
                fold_acc ^= HASH_VALUE_W'(fold_buf);
                hash_q.push_back(fold_acc & HASH_VALUE_W'(wmask));
                fold_buf = 0;
                fold_cnt = 0;
                fold_acc = '0;
            end
        endfunction

        function void compare(string what, logic [31:0] exp_v, logic [31:0] act_v);
            if (exp_v !== act_v)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: %s mismatch: expected %h, got %h",
                             $time, what, exp_v, act_v);
            end
        endfunction

        function void check_hash(logic [HASH_VALUE_W-1:0] act_v);
            if (hash_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0t: hash beat %h with nothing outstanding", $time, act_v);
            end
            else
                compare("hash_value", hash_q.pop_front(), act_v);
        endfunction
    endclass

    logic                  clk;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    xfh_in_if  byte_bus ();
    xfh_out_if hash_bus ();

    hash_scoreboard sb = new;

    bit          quiet     = 1'b0;
    int unsigned gap_pct   = 0;
    int unsigned stall_pct = 0;

    xor_fold_string_hash dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .byte_in  (byte_bus),
        .hash_out (hash_bus),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    initial
    begin
        #TIMEOUT_NS;
        $display("** xor_fold_string_hash: FAILED **");
        $finish;
    end

    always @(posedge clk)
    begin
        if (rst_n && byte_bus.valid && byte_bus.ready)
            sb.note_byte(byte_bus.data_byte, byte_bus.last_byte);
        if (rst_n && hash_bus.valid && hash_bus.ready)
            sb.check_hash(hash_bus.hash_value);
    end

    // hash sink back-pressure
    initial
    begin
        hash_bus.ready <= 1'b0;
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(99) < stall_pct)
            begin
                hash_bus.ready <= 1'b0;
                repeat ($urandom_range(1, 14)) @(posedge clk);
            end
            hash_bus.ready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge clk);
        end
    end

    task automatic apb_cycle(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                             output logic [APB_DATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= HASH_BITS_ADDR;
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        rdata = prdata;
        if (wr)
            sb.set_width(wdata);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_hash_bits(input logic [HASH_BITS_W-1:0] w);
        logic [APB_DATA_W-1:0] v;
        logic [APB_DATA_W-1:0] rd;
        v = $urandom();
        v[HASH_BITS_W-1:0] = w;
        apb_cycle(1'b1, v, rd);
        apb_cycle(1'b0, '0, rd);
        sb.compare("hash_bits readback", APB_DATA_W'(w), rd);
    endtask

    // one beat, with an optional idle burst in front
    task automatic send_byte(input logic [BYTE_BITS-1:0] d, input logic l);
        if (!quiet && $urandom_range(99) < gap_pct)
        begin
            byte_bus.valid <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge clk);
        end
        byte_bus.valid     <= 1'b1;
        byte_bus.data_byte <= d;
        byte_bus.last_byte <= l;
        @(posedge clk);
        while (!byte_bus.ready) @(posedge clk);
    endtask

    task automatic send_bytes(input logic [BYTE_BITS-1:0] q[$], input bit close_word);
        foreach (q[i])
            send_byte(q[i], close_word && (i == q.size() - 1));
    endtask

    // sender holds off until every hash is in and the fold pipe is empty
    task automatic wait_drained();
        byte_bus.valid <= 1'b0;
        @(posedge clk);
        while (sb.hash_q.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [BYTE_BITS-1:0] pick_byte();
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return 8'h00;
        if (r == 1) return 8'hFF;
        return BYTE_BITS'($urandom());
    endfunction

    initial
    begin : stimulus
        logic [APB_DATA_W-1:0] rd;
        int unsigned           word_left;
        int unsigned           nbytes;
        int unsigned           r;
        logic [HASH_BITS_W-1:0] phase_w[12];

        phase_w = '{6'd8, 6'd32, 6'd0, 6'd63, 6'd7, 6'd33, 6'd20, 6'd9, 6'd31, 6'd16,
                    6'd24, 6'd12};
        word_left = 0;

        rst_n              <= 1'b0;
        psel               <= 1'b0;
        penable            <= 1'b0;
        pwrite             <= 1'b0;
        paddr              <= '0;
        pwdata             <= '0;
        byte_bus.valid     <= 1'b0;
        byte_bus.data_byte <= '0;
        byte_bus.last_byte <= 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset width, extremes, clamping, width changes inside a word
        stall_pct = 30;
        apb_cycle(1'b0, '0, rd);
        sb.compare("hash_bits after reset", APB_DATA_W'(HASH_BITS_RST), rd);
        send_bytes('{8'h00}, 1'b1);
        send_bytes('{8'hFF}, 1'b1);
        send_bytes('{8'hFF, 8'h00, 8'hA5}, 1'b1);
        wait_drained();
        set_hash_bits(6'd32);
        send_bytes('{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF}, 1'b1);
        send_bytes('{8'h80, 8'h01, 8'h7E}, 1'b1);
        wait_drained();
        set_hash_bits(6'd0);
        send_bytes('{8'h5A, 8'hC3}, 1'b1);
        wait_drained();
        set_hash_bits(6'd63);
        send_bytes('{8'h12, 8'h34, 8'h56}, 1'b0);
        wait_drained();
        // narrower width with 24 bits buffered: several chunks fold on the next byte
        set_hash_bits(6'd8);
        send_bytes('{8'h9A}, 1'b1);
        wait_drained();
        set_hash_bits(6'd13);
        send_bytes('{8'h01, 8'h02}, 1'b0);
        wait_drained();
        set_hash_bits(6'd31);
        send_bytes('{8'hF0, 8'h0F, 8'hAA}, 1'b1);

        // random phases; a phase may end inside a word, so widths also change mid-word
        for (int p = 0; p < 12; p++)
        begin
            wait_drained();
            quiet     = (p == 11);
            gap_pct   = (p % 4 == 0) ? 0 : (p % 4 == 1) ? 5 : (p % 4 == 2) ? 25 : 60;
            stall_pct = ((p + 1) % 4 == 0) ? 0 : ((p + 1) % 4 == 1) ? 10 : 40;
            set_hash_bits((p < 6) ? phase_w[p] : HASH_BITS_W'($urandom_range(0, 63)));
            nbytes = quiet ? 110 : 90;
            for (int i = 0; i < nbytes; i++)
            begin
                if (word_left == 0)
                begin
                    r = $urandom_range(99);
                    word_left = (r < 70) ? $urandom_range(1, 8)
                              : (r < 95) ? $urandom_range(9, 20) : $urandom_range(21, 48);
                end
                send_byte(pick_byte(), word_left == 1);
                word_left--;
            end
        end
        while (word_left > 0)
        begin
            send_byte(pick_byte(), word_left == 1);
            word_left--;
        end

        wait_drained();
        if (sb.errors == 0)
            $display("** xor_fold_string_hash: PASSED **");
        else
            $display("** xor_fold_string_hash: FAILED **");
        $finish;
    end

endmodule
